/* rtl/core/gcm_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gcm_pkg: shared types and constants of the greedy change maker
// Register indexes, reset values, sequencer states and divider handshake
// structs.
// ----------------------------------------------------------------------------
package gcm_pkg;

    localparam int COIN_INDEX_WIDTH = 3;
    localparam int COIN_COUNT_WIDTH = 3;
    localparam int CFG_INDEX_WIDTH  = 3;
    localparam int NUM_DENOM_REGS   = 6;

    localparam logic [CFG_INDEX_WIDTH-1:0]  CFG_COIN_COUNT    = 3'd0;
    localparam logic [COIN_COUNT_WIDTH-1:0] COIN_COUNT_RESET  = 3'd6;

    localparam int DENOM_RESET [NUM_DENOM_REGS] = '{100, 50, 25, 10, 5, 1};

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOAD,
        ST_DIVIDE,
        ST_PUBLISH
    } gcm_state_t;

    typedef struct packed {
        logic start;
    } gcm_div_ctrl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } gcm_div_status_t;

endpackage

/* rtl/core/gcm_divider.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gcm_divider: bit-serial restoring divider
// Shifts the dividend out one bit per cycle and the quotient in one bit per
// cycle; the result holds until the next start.
// ----------------------------------------------------------------------------
module gcm_divider
    import gcm_pkg::*;
#(
    parameter int AMOUNT_WIDTH = 20,
    parameter int DENOM_WIDTH  = 16
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  gcm_div_ctrl_t           ctrl,
    input  logic [AMOUNT_WIDTH-1:0] dividend,
    input  logic [DENOM_WIDTH-1:0]  divisor,
    output gcm_div_status_t         status,
    output logic [AMOUNT_WIDTH-1:0] quotient,
    output logic [AMOUNT_WIDTH-1:0] remainder
);

    localparam int CW = $clog2(AMOUNT_WIDTH + 1);
    localparam int RW = (DENOM_WIDTH > AMOUNT_WIDTH) ? DENOM_WIDTH : AMOUNT_WIDTH;

    logic                    busy_reg, busy_next;
    logic                    done_reg, done_next;
    logic [CW-1:0]           cnt_reg, cnt_next;
    logic [DENOM_WIDTH-1:0]  r_reg, r_next;
    logic [AMOUNT_WIDTH-1:0] q_reg, q_next;
    logic [DENOM_WIDTH-1:0]  d_reg, d_next;
    logic [DENOM_WIDTH:0]    trial;
    logic                    fits;
    logic [RW-1:0]           rem_wide;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        r_reg <= r_next;
        q_reg <= q_next;
        d_reg <= d_next;
    end

    always_comb begin
        trial     = {r_reg, q_reg[AMOUNT_WIDTH-1]} - {1'b0, d_reg};
        fits      = !trial[DENOM_WIDTH];
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        r_next    = r_reg;
        q_next    = q_reg;
        d_next    = d_reg;
        if (ctrl.start) begin
            busy_next = 1'b1;
            cnt_next  = CW'(AMOUNT_WIDTH);
            r_next    = '0;
            q_next    = dividend;
            d_next    = divisor;
        end else if (busy_reg) begin
            // shift in one dividend bit, subtract if it fits
            r_next   = fits ? trial[DENOM_WIDTH-1:0]
                            : {r_reg[DENOM_WIDTH-2:0], q_reg[AMOUNT_WIDTH-1]};
            q_next   = {q_reg[AMOUNT_WIDTH-2:0], fits};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    assign rem_wide    = RW'(r_reg);
    assign quotient    = q_reg;
    assign remainder   = rem_wide[AMOUNT_WIDTH-1:0];
    assign status.busy = busy_reg;
    assign status.done = done_reg;

endmodule

/* rtl/core/gcm_cfg_regs.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gcm_cfg_regs: configuration register file
// Holds the coin count and the denominations; derives the index of the last
// denomination in use.
// ----------------------------------------------------------------------------
module gcm_cfg_regs
    import gcm_pkg::*;
#(
    parameter int MAX_COINS   = 6,
    parameter int DENOM_WIDTH = 16
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_we,
    input  logic [CFG_INDEX_WIDTH-1:0]  cfg_index,
    input  logic [DENOM_WIDTH-1:0]      cfg_data,
    output logic [DENOM_WIDTH-1:0]      denom [MAX_COINS],
    output logic [COIN_INDEX_WIDTH-1:0] last_index
);

    localparam int IDXW = (MAX_COINS > 1) ? $clog2(MAX_COINS) : 1;

    logic [COIN_COUNT_WIDTH-1:0] coin_count_reg;
    logic [DENOM_WIDTH-1:0]      denom_reg [MAX_COINS];
    logic [CFG_INDEX_WIDTH-1:0]  slot;

    assign slot = cfg_index - 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            coin_count_reg <= COIN_COUNT_RESET;
            for (int i = 0; i < MAX_COINS; i++) begin
                denom_reg[i] <= DENOM_WIDTH'(DENOM_RESET[i]);
            end
        end else if (cfg_we) begin
            if (cfg_index == CFG_COIN_COUNT) begin
                coin_count_reg <= cfg_data[COIN_COUNT_WIDTH-1:0];
            end else if (int'(slot) < MAX_COINS) begin
                denom_reg[slot[IDXW-1:0]] <= cfg_data;
            end
        end
    end

    always_comb begin
        priority if (coin_count_reg == '0) begin
            last_index = '0;
        end else if (int'(coin_count_reg) > MAX_COINS) begin
            last_index = COIN_INDEX_WIDTH'(MAX_COINS - 1);
        end else begin
            last_index = COIN_INDEX_WIDTH'(coin_count_reg - 1'b1);
        end
    end

    assign denom = denom_reg;

endmodule

/* rtl/core/greedy_change_maker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// greedy_change_maker: greedy coin change over configured denominations
// Pays out each amount word greedily over the denominations in index order
// and returns one result word per denomination in use.
// ----------------------------------------------------------------------------
// An amount word is taken only when the previous one has been fully worked
// through; it then yields one result word per denomination in use, index 0
// first, with tlast on the final one. Each nonzero denomination is divided
// by a shared bit-serial divider that retires one quotient bit per cycle;
// a zero denomination bypasses the divider. A result word may wait in the
// output register while the next division runs.
module greedy_change_maker
    import gcm_pkg::*;
#(
    parameter int MAX_COINS    = 6,
    parameter int AMOUNT_WIDTH = 20,
    parameter int DENOM_WIDTH  = 16
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    // configuration
    input  logic                                  cfg_we,
    input  logic [CFG_INDEX_WIDTH-1:0]            cfg_index,
    input  logic [DENOM_WIDTH-1:0]                cfg_data,
    // amount words
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    input  logic [((AMOUNT_WIDTH+7)/8)*8-1:0]     s_tdata,  // amount
    // result words
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    // coin_index, coins_given, leftover
    output logic [((2*AMOUNT_WIDTH+10)/8)*8-1:0]  m_tdata,
    output logic                                  m_tlast
);

    localparam int IDXW  = (MAX_COINS > 1) ? $clog2(MAX_COINS) : 1;
    localparam int OUT_W = ((2 * AMOUNT_WIDTH + 10) / 8) * 8;

    gcm_state_t                  state_reg, state_next;
    logic [AMOUNT_WIDTH-1:0]     rem_reg, rem_next;
    logic [COIN_INDEX_WIDTH-1:0] idx_reg, idx_next;
    logic                        zero_reg, zero_next;
    logic                        m_tvalid_reg, m_tvalid_next;
    logic [COIN_INDEX_WIDTH-1:0] out_index_reg, out_index_next;
    logic [AMOUNT_WIDTH-1:0]     out_count_reg, out_count_next;
    logic [AMOUNT_WIDTH-1:0]     out_left_reg, out_left_next;
    logic                        out_last_reg, out_last_next;

    logic [DENOM_WIDTH-1:0]      denom [MAX_COINS];
    logic [COIN_INDEX_WIDTH-1:0] last_index;
    logic [DENOM_WIDTH-1:0]      denom_sel;
    gcm_div_ctrl_t               div_ctrl;
    gcm_div_status_t             div_status;
    logic [AMOUNT_WIDTH-1:0]     div_quot;
    logic [AMOUNT_WIDTH-1:0]     div_rem;
    logic [AMOUNT_WIDTH-1:0]     res_count;
    logic [AMOUNT_WIDTH-1:0]     res_left;
    logic                        slot_free;
    logic                        publish;

    gcm_cfg_regs #(
        .MAX_COINS   (MAX_COINS),
        .DENOM_WIDTH (DENOM_WIDTH)
    ) u_cfg (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .denom      (denom),
        .last_index (last_index)
    );

    gcm_divider #(
        .AMOUNT_WIDTH (AMOUNT_WIDTH),
        .DENOM_WIDTH  (DENOM_WIDTH)
    ) u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctrl      (div_ctrl),
        .dividend  (rem_reg),
        .divisor   (denom_sel),
        .status    (div_status),
        .quotient  (div_quot),
        .remainder (div_rem)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
        rem_reg       <= rem_next;
        idx_reg       <= idx_next;
        zero_reg      <= zero_next;
        out_index_reg <= out_index_next;
        out_count_reg <= out_count_next;
        out_left_reg  <= out_left_next;
        out_last_reg  <= out_last_next;
    end

    assign denom_sel = denom[idx_reg[IDXW-1:0]];
    assign res_count = zero_reg ? '0 : div_quot;
    assign res_left  = zero_reg ? rem_reg : div_rem;
    assign slot_free = !m_tvalid_reg || m_tready;
    assign publish   = slot_free && ((state_reg == ST_PUBLISH) ||
                                     (state_reg == ST_DIVIDE && div_status.done));

    always_comb begin
        state_next     = state_reg;
        rem_next       = rem_reg;
        idx_next       = idx_reg;
        zero_next      = zero_reg;
        div_ctrl.start = 1'b0;
        s_tready       = 1'b0;
        m_tvalid_next  = m_tvalid_reg && !m_tready;
        out_index_next = out_index_reg;
        out_count_next = out_count_reg;
        out_left_next  = out_left_reg;
        out_last_next  = out_last_reg;

        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    rem_next   = s_tdata[AMOUNT_WIDTH-1:0];
                    idx_next   = '0;
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD: begin
                // zero denomination: bypass the divider
                zero_next = (denom_sel == '0);
                if (denom_sel == '0) begin
                    state_next = ST_PUBLISH;
                end else begin
                    div_ctrl.start = 1'b1;
                    state_next     = ST_DIVIDE;
                end
            end
            ST_DIVIDE: begin
                if (div_status.done && !slot_free) begin
                    state_next = ST_PUBLISH;
                end
            end
            ST_PUBLISH: begin
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        if (publish) begin
            m_tvalid_next  = 1'b1;
            out_index_next = idx_reg;
            out_count_next = res_count;
            out_left_next  = res_left;
            out_last_next  = (idx_reg == last_index);
            rem_next       = res_left;
            if (idx_reg == last_index) begin
                state_next = ST_IDLE;
            end else begin
                idx_next   = idx_reg + 1'b1;
                state_next = ST_LOAD;
            end
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = OUT_W'({out_left_reg, out_count_reg, out_index_reg});
    assign m_tlast  = out_last_reg;

`ifndef SYNTHESIS
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE) |-> !div_status.busy)
        else $error("divider busy while sequencer idle");

    assert property (@(posedge aclk) disable iff (!aresetn)
        div_status.done |-> (state_reg == ST_DIVIDE))
        else $error("divider finished outside a division");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("amount word taken while previous one in progress");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg |-> (out_index_reg <= last_index))
        else $error("result word beyond last denomination in use");
`endif

endmodule
